/* src/checksummed_frame_receiver_echo_unit_defines.svh */
// Assertion macros used by the checker file of the frame receiver echo unit
`ifndef CHECKSUMMED_FRAME_RECEIVER_ECHO_UNIT_DEFINES_SVH
`define CHECKSUMMED_FRAME_RECEIVER_ECHO_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define CRFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define CRFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/crfe_pkg.sv */
// Types and constants shared by the frame receiver echo unit modules
package crfe_pkg;

    localparam int unsigned SYM_W     = 7;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PAYLOAD_W = 3 * SYM_W;

    // Bit 7 of a received word marks a check word
    localparam int unsigned MARK_POS = 7;

    // Both fixed check terms folded into one mask
    localparam logic [SYM_W-1:0] CHECK_XOR_A = 7'h7f;
    localparam logic [SYM_W-1:0] CHECK_XOR_B = 7'h55;
    localparam logic [SYM_W-1:0] CHECK_XOR   = CHECK_XOR_A ^ CHECK_XOR_B;

    // Echo beat order
    typedef enum logic [1:0] {
        BEAT_CHECK = 2'd0,
        BEAT_D2    = 2'd1,
        BEAT_D1    = 2'd2,
        BEAT_D0    = 2'd3
    } beat_t;

    // One completed frame handed from the decoder to the echo sequencer
    typedef struct packed {
        logic             err;
        logic [SYM_W-1:0] chk;
        logic [SYM_W-1:0] d2;
        logic [SYM_W-1:0] d1;
        logic [SYM_W-1:0] d0;
    } frame_t;

endpackage

/* src/crfe_frame.sv */
// Input register and frame decoder: collects check and data words, flags completed frames
module crfe_frame
    import crfe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   rx_byte,
    output logic                frame_valid,
    input  logic                frame_ready,
    output frame_t              frame
);

    logic                in_vld_reg;
    logic [BYTE_W-1:0]   rx_reg;
    logic [1:0]          count_reg;
    logic [SYM_W-1:0]    check_reg;
    logic [SYM_W-1:0]    data_reg [2];

    logic                is_mark;
    logic [SYM_W-1:0]    sym;
    logic                completes;
    logic                advance;
    logic [SYM_W-1:0]    expect_chk;

    assign is_mark = rx_reg[MARK_POS];
    assign sym     = rx_reg[SYM_W-1:0];

    // Third data word closes a frame (count of two or more)
    assign completes = in_vld_reg && !is_mark && count_reg[1];
    assign advance   = in_vld_reg && (!completes || frame_ready);
    assign in_stall  = in_vld_reg && !advance;

    // Checksum compare
    assign expect_chk  = sym ^ data_reg[1] ^ data_reg[0] ^ CHECK_XOR;
    assign frame_valid = completes;
    assign frame.err   = (expect_chk != check_reg);
    assign frame.chk   = check_reg;
    assign frame.d2    = data_reg[0];
    assign frame.d1    = data_reg[1];
    assign frame.d0    = sym;

    // Input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            rx_reg <= rx_byte;
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 2'd0;
            check_reg   <= '0;
            data_reg[0] <= '0;
            data_reg[1] <= '0;
        end
        else if (advance)
        begin
            if (is_mark)
            begin
                check_reg <= sym;
                count_reg <= 2'd0;
            end
            else if (!count_reg[1])
            begin
                data_reg[count_reg[0]] <= sym;
                count_reg              <= count_reg + 2'd1;
            end
            else
            begin
                count_reg <= 2'd0;
            end
        end
    end

endmodule

/* src/crfe_echo.sv */
// Result register and echo sequencer: plays out four echo words or one error word per frame
module crfe_echo
    import crfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  frame_valid,
    output logic                  frame_ready,
    input  frame_t                frame,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  status,
    output logic [BYTE_W-1:0]     tx_byte,
    output logic [PAYLOAD_W-1:0]  payload,
    output logic [SYM_W-1:0]      received_check,
    output logic                  last
);

    logic    vld_reg;
    frame_t  frame_reg;
    beat_t   beat_reg;

    logic              fire;
    logic [SYM_W-1:0]  beat_sym;

    assign fire        = vld_reg && !out_stall;
    assign last        = frame_reg.err || (beat_reg == BEAT_D0);
    assign frame_ready = !vld_reg || (fire && last);

    // Word select for the current beat
    always_comb
    begin
        case (beat_reg)
            BEAT_CHECK: beat_sym = frame_reg.chk;
            BEAT_D2:    beat_sym = frame_reg.d2;
            BEAT_D1:    beat_sym = frame_reg.d1;
            BEAT_D0:    beat_sym = frame_reg.d0;
            default:    beat_sym = frame_reg.d0;
        endcase
    end

    assign out_valid      = vld_reg;
    assign status         = frame_reg.err;
    assign received_check = frame_reg.chk;
    assign tx_byte        = frame_reg.err ? '0 :
                            {(beat_reg == BEAT_CHECK), beat_sym};
    assign payload        = frame_reg.err ? '0 :
                            {frame_reg.d2, frame_reg.d1, frame_reg.d0};

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            beat_reg <= BEAT_CHECK;
        end
        else if (frame_ready)
        begin
            vld_reg  <= frame_valid;
            beat_reg <= BEAT_CHECK;
        end
        else if (fire)
        begin
            beat_reg <= beat_t'(beat_reg + 2'd1);
        end
    end

    // Frame hold register
    always_ff @(posedge clk)
    begin
        if (frame_ready && frame_valid)
        begin
            frame_reg <= frame;
        end
    end

endmodule

/* src/checksummed_frame_receiver_echo_unit.sv */
// Top level of the checksummed frame receiver echo unit
// Accepts one received word per clock while in_stall is low. A check word (bit 7
// set) or a data word that does not finish a frame passes through the input register
// and gives no result. The third data word of a frame is held in the input
// register until the result register is free, then yields either four echo
// words (check with bit 7 set, d2, d1, d0, each with the 21-bit payload) or a
// single error word when the checksum misses; last marks the final one. While
// the four-beat output sequencer is busy, the third data word of the next frame
// waits in the input register and stalls the input; a result word reaches the
// output through the input register and then the result register.
module checksummed_frame_receiver_echo_unit
    import crfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  status,
    output logic [BYTE_W-1:0]     tx_byte,
    output logic [PAYLOAD_W-1:0]  payload,
    output logic [SYM_W-1:0]      received_check,
    output logic                  last
);

    logic    frame_valid;
    logic    frame_ready;
    frame_t  frame;

    crfe_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    crfe_echo u_echo (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame_ready    (frame_ready),
        .frame          (frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .tx_byte        (tx_byte),
        .payload        (payload),
        .received_check (received_check),
        .last           (last)
    );

endmodule

/* src/crfe_checker.sv */
// Port-level checker for the frame receiver echo unit, bound to the top level
`include "checksummed_frame_receiver_echo_unit_defines.svh"

module crfe_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         out_valid,
    input logic         out_stall,
    input logic         status,
    input logic [7:0]   tx_byte,
    input logic [20:0]  payload,
    input logic [6:0]   received_check,
    input logic         last
);

    // Stalled result word holds
    `CRFE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(tx_byte) && $stable(payload) && $stable(last), "stalled result word changed")

    // Error word is a single, zeroed word
    `CRFE_ASSERT_NOW(a_err_word, clk, rst_n, out_valid && status, last && (tx_byte == 8'd0) && (payload == 21'd0), "error word malformed")

    // Echo beats follow without gaps and keep the frame fields
    `CRFE_ASSERT_NEXT(a_echo_run, clk, rst_n, out_valid && !out_stall && !last, out_valid && !status && $stable(payload) && $stable(received_check), "echo sequence broken")

    // Leading echo word carries the stored check
    `CRFE_ASSERT_NOW(a_echo_check, clk, rst_n, out_valid && !status && tx_byte[7], (tx_byte[6:0] == received_check) && !last, "check echo word wrong")

endmodule

bind checksummed_frame_receiver_echo_unit crfe_checker u_crfe_checker (.*);
